// ----- src/ptd_pkg.sv -----
// Package: shared constants and types of the periodic task dispatcher.
package ptd_pkg;
  localparam int unsigned GROUPS = 2;
  localparam int unsigned TASKS = GROUPS * 32;
  localparam int unsigned IDX_W = $clog2(TASKS);

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_ADD  = 2'd2;
  localparam logic [1:0] OP_DEL  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_PRESENT  = 3'd2;
  localparam logic [2:0] ST_ABSENT   = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_MISSED   = 3'd5;
  localparam logic [2:0] ST_LATE     = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  task_id;
    logic [15:0] handler_tag;
    logic [15:0] period;
    logic [15:0] start_tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        dispatch_valid;
    logic [7:0]  dispatch_id;
    logic [15:0] dispatch_tag;
    logic        tick_out;
  } out_item_t;
endpackage

// ----- src/ptd_if.sv -----
// Interface: valid/ready channel carrying one payload struct.
interface ptd_in_if;
  logic               valid;
  logic               ready;
  ptd_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptd_out_if;
  logic               valid;
  logic               ready;
  ptd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/periodic_task_dispatcher.sv -----
// Top level: periodic task dispatcher with a table swept one entry a cycle.
// Usage: in_ch carries opcode beats (tick, run, add, delete); out_ch returns
// exactly one result beat per input beat, in order.
// Tick, add, delete and runs in the init phase pass through the read and
// evaluate states to the output state. An update run sweeps all TASKS
// entries, one per cycle, through a shared elapsed-time subtract and compare.
// An execute run scans pending bits one entry per cycle until the lowest
// pending task is found or the last entry has been scanned.
// Add and delete read the task entry in one cycle and write in the next.
// One item is in work at a time; in_ready is low while busy. The result sits
// in an output register; in_ready returns once the result is taken, so a
// stalled receiver holds the block.
// Reset clears tick count, phase and the enable and pending bits; table
// entries that are not enabled are never read, so no clearing pass is needed.
module periodic_task_dispatcher (
  input logic clk,
  input logic rst_n,
  ptd_in_if.sink in_ch,
  ptd_out_if.source out_ch
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EVAL = 5'b00100,
    S_SWEEP = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam logic [1:0] PH_INIT = 2'd0;
  localparam logic [1:0] PH_UPDATE = 2'd1;
  localparam logic [1:0] PH_EXECUTE = 2'd2;

  state_t state_r, state_nxt;
  ptd_pkg::in_item_t item_r;
  ptd_pkg::out_item_t res_r;
  logic [31:0] tick_r;
  logic [1:0] phase_r;
  logic sweep_exec_r;
  logic [ptd_pkg::TASKS-1:0] en_r, pend_r;
  logic [ptd_pkg::IDX_W:0] idx_r;
  logic [ptd_pkg::IDX_W-1:0] ix;

  logic [15:0] per_mem [ptd_pkg::TASKS];
  logic [31:0] start_mem [ptd_pkg::TASKS];
  logic [15:0] tag_mem [ptd_pkg::TASKS];
  logic [15:0] per_q, tag_q;
  logic [31:0] start_q;
  logic [ptd_pkg::IDX_W-1:0] q_idx_r;
  logic q_en_r, q_pend_r;

  logic [31:0] elapsed;
  logic due, half;
  logic wr_en;
  logic [ptd_pkg::IDX_W-1:0] wr_idx;
  logic [15:0] wr_per, wr_tag;
  logic [31:0] wr_start;
  logic in_range;

  assign ix = idx_r[ptd_pkg::IDX_W-1:0];
  assign in_range = {1'b0, item_r.task_id} < 9'(ptd_pkg::TASKS);
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = res_r;

  // Shared elapsed-time unit.
  assign elapsed = tick_r - start_q;
  assign due = elapsed >= {16'd0, per_q};
  assign half = elapsed >= {17'd0, per_q[15:1]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      per_mem[wr_idx] <= wr_per;
      start_mem[wr_idx] <= wr_start;
      tag_mem[wr_idx] <= wr_tag;
    end
    per_q <= per_mem[ix];
    start_q <= start_mem[ix];
    tag_q <= tag_mem[ix];
    q_idx_r <= ix;
    q_en_r <= en_r[ix];
    q_pend_r <= pend_r[ix];
  end

  always_comb begin
    wr_en = 1'b0;
    wr_idx = q_idx_r;
    wr_per = per_q;
    wr_tag = tag_q;
    wr_start = start_q + {16'd0, per_q};
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        if (item_r.opcode == ptd_pkg::OP_ADD && in_range && !q_en_r) begin
          wr_en = 1'b1;
          wr_per = item_r.period;
          wr_tag = item_r.handler_tag;
          wr_start = {16'd0, item_r.start_tick};
        end
        state_nxt = S_OUT;
        if (item_r.opcode == ptd_pkg::OP_RUN &&
            (phase_r == PH_UPDATE || phase_r == PH_EXECUTE)) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        // q_* holds the entry of the previous index.
        if (!sweep_exec_r && q_en_r && due) wr_en = 1'b1;
        if (sweep_exec_r && q_pend_r && due) wr_en = 1'b1;
        if ((sweep_exec_r && q_pend_r) ||
            q_idx_r == ptd_pkg::IDX_W'(ptd_pkg::TASKS - 1)) state_nxt = S_OUT;
      end
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r <= '0;
      phase_r <= PH_INIT;
      en_r <= '0;
      pend_r <= '0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          item_r <= in_ch.data;
          res_r <= '0;
          idx_r <= {1'b0, in_ch.data.task_id[ptd_pkg::IDX_W-1:0]};
        end
        S_READ: begin
          // Point at entry 0 so the sweep starts with it.
          if (item_r.opcode == ptd_pkg::OP_RUN) idx_r <= '0;
        end
        S_EVAL: begin
          case (item_r.opcode)
            ptd_pkg::OP_TICK: begin
              tick_r <= tick_r + 32'd1;
              res_r.tick_out <= 1'b1;
            end
            ptd_pkg::OP_RUN: begin
              idx_r <= {{ptd_pkg::IDX_W{1'b0}}, 1'b1};
              sweep_exec_r <= (phase_r == PH_EXECUTE);
              if (phase_r == PH_UPDATE) phase_r <= PH_EXECUTE;
              else phase_r <= PH_UPDATE;
            end
            default: begin
              if (!in_range) res_r.status <= ptd_pkg::ST_RANGE;
              else if (item_r.opcode == ptd_pkg::OP_ADD) begin
                if (q_en_r) res_r.status <= ptd_pkg::ST_PRESENT;
                else en_r[q_idx_r] <= 1'b1;
              end else begin
                if (!q_en_r) res_r.status <= ptd_pkg::ST_ABSENT;
                else if (tag_q != item_r.handler_tag)
                  res_r.status <= ptd_pkg::ST_MISMATCH;
                else begin
                  // Entry left stale; disabled entries are never read.
                  en_r[q_idx_r] <= 1'b0;
                  pend_r[q_idx_r] <= 1'b0;
                end
              end
            end
          endcase
        end
        S_SWEEP: begin
          idx_r <= idx_r + 1'b1;
          if (!sweep_exec_r) begin
            if (q_en_r && due) pend_r[q_idx_r] <= 1'b1;
          end else if (q_pend_r) begin
            pend_r[q_idx_r] <= 1'b0;
            if (per_q == 16'd0) en_r[q_idx_r] <= 1'b0;
            res_r.dispatch_valid <= 1'b1;
            res_r.dispatch_id <= 8'(q_idx_r);
            res_r.dispatch_tag <= tag_q;
            res_r.status <= due ? ptd_pkg::ST_MISSED :
                            (half ? ptd_pkg::ST_LATE : ptd_pkg::ST_OK);
          end
        end
        default: ;
      endcase
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid |-> !in_ch.ready)) else $error("ready while result held");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data)))
    else $error("result dropped");
endmodule

// ----- tb/ptd_checker.sv -----
// Checker: mirrors the dispatcher state, predicts each result beat and compares it.
module ptd_checker (
  input  logic clk,
  input  logic rst_n,
  ptd_in_if    in_ch,
  ptd_out_if   out_ch,
  output int   fail_count,
  output int   pending_count
);
  typedef enum logic [1:0] {PH_INIT, PH_UPDATE, PH_EXECUTE} phase_t;

  logic [31:0]               tick_q;
  logic [ptd_pkg::TASKS-1:0] enabled_q;
  logic [ptd_pkg::TASKS-1:0] due_q;
  logic [15:0]               period_q [ptd_pkg::TASKS];
  logic [31:0]               start_q  [ptd_pkg::TASKS];
  logic [15:0]               tag_q    [ptd_pkg::TASKS];
  phase_t                    phase_q;
  ptd_pkg::out_item_t        result_fifo [$];

  function automatic void sweep_due();
    logic [31:0] elapsed;
    for (int k = 0; k < ptd_pkg::TASKS; k++) begin
      elapsed = tick_q - start_q[k];
      if (enabled_q[k] && elapsed >= {16'd0, period_q[k]}) begin
        due_q[k] = 1'b1;
        start_q[k] = start_q[k] + {16'd0, period_q[k]};
      end
    end
  endfunction

  function automatic void dispatch_lowest(inout ptd_pkg::out_item_t r);
    logic [31:0] elapsed;
    logic [31:0] per;
    for (int k = 0; k < ptd_pkg::TASKS; k++) begin
      if (due_q[k]) begin
        per = {16'd0, period_q[k]};
        due_q[k] = 1'b0;
        if (per == 0) enabled_q[k] = 1'b0;
        elapsed = tick_q - start_q[k];
        if (elapsed >= per) begin
          r.status = ptd_pkg::ST_MISSED;
          start_q[k] = start_q[k] + per;
        end else if (elapsed >= (per >> 1)) begin
          r.status = ptd_pkg::ST_LATE;
        end else begin
          r.status = ptd_pkg::ST_OK;
        end
        r.dispatch_valid = 1'b1;
        r.dispatch_id = 8'(k);
        r.dispatch_tag = tag_q[k];
        return;
      end
    end
  endfunction

  function automatic ptd_pkg::out_item_t predict_result(input ptd_pkg::in_item_t it);
    ptd_pkg::out_item_t r;
    int                 id;
    r = '0;
    id = it.task_id;
    case (it.opcode)
      ptd_pkg::OP_TICK: begin
        tick_q = tick_q + 1;
        r.tick_out = 1'b1;
      end
      ptd_pkg::OP_RUN: begin
        if (phase_q == PH_UPDATE) begin
          sweep_due();
          phase_q = PH_EXECUTE;
        end else if (phase_q == PH_EXECUTE) begin
          dispatch_lowest(r);
          phase_q = PH_UPDATE;
        end else begin
          phase_q = PH_UPDATE;
        end
      end
      default: begin
        if (id >= ptd_pkg::TASKS) begin
          r.status = ptd_pkg::ST_RANGE;
        end else if (it.opcode == ptd_pkg::OP_ADD) begin
          if (enabled_q[id]) begin
            r.status = ptd_pkg::ST_PRESENT;
          end else begin
            enabled_q[id] = 1'b1;
            tag_q[id] = it.handler_tag;
            period_q[id] = it.period;
            start_q[id] = {16'd0, it.start_tick};
          end
        end else begin
          if (!enabled_q[id]) begin
            r.status = ptd_pkg::ST_ABSENT;
          end else if (tag_q[id] != it.handler_tag) begin
            r.status = ptd_pkg::ST_MISMATCH;
          end else begin
            due_q[id] = 1'b0;
            enabled_q[id] = 1'b0;
            tag_q[id] = '0;
            period_q[id] = '0;
            start_q[id] = '0;
          end
        end
      end
    endcase
    return r;
  endfunction

  assign pending_count = result_fifo.size();

  always @(posedge clk) begin
    ptd_pkg::out_item_t want;
    ptd_pkg::out_item_t got;
    if (!rst_n) begin
      tick_q <= '0;
      enabled_q <= '0;
      due_q <= '0;
      phase_q <= PH_INIT;
      for (int k = 0; k < ptd_pkg::TASKS; k++) begin
        period_q[k] <= '0;
        start_q[k] <= '0;
        tag_q[k] <= '0;
      end
      result_fifo.delete();
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) result_fifo.push_back(predict_result(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (result_fifo.size() == 0) begin
          $error("result beat with nothing expected: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo.pop_front();
          if (want != got) begin
            fail_count <= fail_count + 1;
            if (want.status != got.status)
              $error("status: expected %0d, actual %0d", want.status, got.status);
            if (want.dispatch_valid != got.dispatch_valid)
              $error("dispatch_valid: expected %0d, actual %0d",
                     want.dispatch_valid, got.dispatch_valid);
            if (want.dispatch_id != got.dispatch_id)
              $error("dispatch_id: expected %0d, actual %0d", want.dispatch_id, got.dispatch_id);
            if (want.dispatch_tag != got.dispatch_tag)
              $error("dispatch_tag: expected %h, actual %h", want.dispatch_tag, got.dispatch_tag);
            if (want.tick_out != got.tick_out)
              $error("tick_out: expected %0d, actual %0d", want.tick_out, got.tick_out);
          end
        end
      end
    end
  end
endmodule

// ----- tb/periodic_task_dispatcher_tb.sv -----
// Testbench top: drives opcode beats and result back-pressure, and gives the verdict.
module periodic_task_dispatcher_tb;
  localparam int RANDOM_ITEMS = 1620;
  localparam int QUIET_FROM   = RANDOM_ITEMS - 200;
  localparam int STALL_AT     = 400;
  localparam int STALL_LEN    = 300;
  localparam int IDLE_LIMIT   = 3000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   sent_count;
  int   ticks_sent;
  int   hold_cnt;
  int   idle_cycles;
  bit   quiet;
  bit   stalled_once;
  logic [15:0] added_tag [256];

  ptd_in_if  in_ch ();
  ptd_out_if out_ch ();

  periodic_task_dispatcher u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  ptd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stall bursts, one long hold-off to back the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      stalled_once <= 1'b0;
      hold_cnt <= 0;
      out_ch.ready <= 1'b0;
    end else if (!stalled_once && sent_count >= STALL_AT) begin
      stalled_once <= 1'b1;
      hold_cnt <= STALL_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      hold_cnt <= $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input ptd_pkg::in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    if (it.opcode == ptd_pkg::OP_TICK) ticks_sent++;
    if (it.opcode == ptd_pkg::OP_ADD) added_tag[it.task_id] = it.handler_tag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic ptd_pkg::in_item_t make_beat(input logic [1:0] op, input logic [7:0] id,
                                                  input logic [15:0] tag,
                                                  input logic [15:0] per,
                                                  input logic [15:0] st);
    ptd_pkg::in_item_t it;
    it.opcode = op;
    it.task_id = id;
    it.handler_tag = tag;
    it.period = per;
    it.start_tick = st;
    return it;
  endfunction

  function automatic ptd_pkg::in_item_t random_beat();
    ptd_pkg::in_item_t it;
    int                pick;
    it = ptd_pkg::in_item_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 30) it.opcode = ptd_pkg::OP_TICK;
    else if (pick < 65) it.opcode = ptd_pkg::OP_RUN;
    else if (pick < 85) it.opcode = ptd_pkg::OP_ADD;
    else it.opcode = ptd_pkg::OP_DEL;
    if ($urandom_range(0, 9) != 0) it.task_id = 8'($urandom_range(0, ptd_pkg::TASKS - 1));
    pick = $urandom_range(0, 9);
    if (pick < 6) it.period = 16'($urandom_range(0, 16));
    else if (pick < 9) it.period = 16'($urandom_range(17, 300));
    if ($urandom_range(0, 9) < 7) it.start_tick = 16'(ticks_sent - $urandom_range(0, 20));
    // Mostly use the tag that was stored, so deletes reach the success path.
    if (it.opcode == ptd_pkg::OP_DEL && $urandom_range(0, 9) < 7)
      it.handler_tag = added_tag[it.task_id];
    return it;
  endfunction

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    quiet = 1'b0;
    sent_count = 0;
    ticks_sent = 0;
    foreach (added_tag[i]) added_tag[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Leave init, empty update, empty execute.
    repeat (3) send_beat(make_beat(ptd_pkg::OP_RUN, 8'd0, 16'd0, 16'd0, 16'd0));
    send_beat(make_beat(ptd_pkg::OP_ADD, 8'd0, 16'hFFFF, 16'd0, 16'd0));
    send_beat(make_beat(ptd_pkg::OP_ADD, 8'd63, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(ptd_pkg::OP_ADD, 8'd0, 16'h1111, 16'd3, 16'd3));
    send_beat(make_beat(ptd_pkg::OP_ADD, 8'd64, 16'd0, 16'd0, 16'd0));
    send_beat(make_beat(ptd_pkg::OP_ADD, 8'd255, 16'd0, 16'd0, 16'd0));
    send_beat(make_beat(ptd_pkg::OP_DEL, 8'd255, 16'd0, 16'd0, 16'd0));
    send_beat(make_beat(ptd_pkg::OP_DEL, 8'd5, 16'd0, 16'd0, 16'd0));
    send_beat(make_beat(ptd_pkg::OP_DEL, 8'd63, 16'd1, 16'd0, 16'd0));
    repeat (7) send_beat(make_beat(ptd_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 16'd0));
    // Task 4 comes out on time; task 5 is not due yet.
    send_beat(make_beat(ptd_pkg::OP_ADD, 8'd4, 16'h1234, 16'd4, 16'd2));
    send_beat(make_beat(ptd_pkg::OP_ADD, 8'd5, 16'h5678, 16'd4, 16'd4));
    repeat (6) send_beat(make_beat(ptd_pkg::OP_RUN, 8'd0, 16'd0, 16'd0, 16'd0));
    send_beat(make_beat(ptd_pkg::OP_DEL, 8'd63, 16'd0, 16'd0, 16'd0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= QUIET_FROM) quiet = 1'b1;
      send_beat(random_beat());
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
